>>> rtl/event_ring_queue_drop_on_full_top_macros.svh
// assertion macros for the event ring queue checker
// no dependencies; included by the checker file
`ifndef EVENT_RING_QUEUE_DROP_ON_FULL_TOP_MACROS_SVH
`define EVENT_RING_QUEUE_DROP_ON_FULL_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define ERQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ERQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/erq_pkg.sv
// types and constants shared by the event ring queue modules
// no dependencies
package erq_pkg;

  localparam int FIELD_W  = 32;
  localparam int EVT_W    = 6 * FIELD_W;
  localparam int OCC_W    = 6;
  localparam int CNT_W    = 32;
  localparam int S_DATA_W = EVT_W;
  localparam int M_BITS   = EVT_W + OCC_W + 2 * CNT_W;
  localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;
  localparam int M_PAD_W  = M_DATA_W - M_BITS;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic accept;
    logic fetch_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_hit;
  } dp_sts_t;

endpackage

>>> rtl/event_ring_queue_drop_on_full_top.sv
// top level of the event ring queue with drop on full
// depends on erq_pkg, erq_ctrl, erq_dpath
//
// usage
//   input stream s_*: one request per transfer; s_tuser selects push (0) or pop (1),
//   s_tdata carries the event to push (ignored on a pop)
//   output stream m_*: exactly one result per request, in request order;
//   m_tuser is ok, m_tdata holds the popped event (zero unless a pop
//   returned one), occupancy after the request, dropped and push counters
//   a push on a full queue (RING_DEPTH-1 events held) is dropped and counted
// sequencing and throughput
//   push or pop of an empty queue: result valid in the cycle after the request
//   pop of a held event: the event ram read is registered, then ST_FETCH loads it into the result
//   sustained: one push per cycle while m_tready is high; no request is taken during a pop's ST_FETCH
// reset
//   clears indices and counters; ram contents are not cleared
// stalls
//   a result waits in the output register while m_tready is low; a new
//   request is taken in the cycle that register is emptied or drained
module event_ring_queue_drop_on_full_top
  import erq_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // in_kind, in_action, in_x, in_y, in_pressure, in_pointer
  input  logic                s_tuser,   // req_type
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // out_kind, out_action, out_x, out_y, out_pressure,
                                         // out_pointer, occupancy, drop_count, push_count, pad
  output logic                m_tuser    // ok
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  erq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  erq_dpath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

>>> rtl/erq_ctrl.sv
// controller state machine of the event ring queue: handshakes and sequencing
// depends on erq_pkg
module erq_ctrl
  import erq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !m_tready;
    s_tready       = 1'b0;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = !out_valid || m_tready;
        cmd.accept = s_tvalid && s_tready;
        if (cmd.accept) begin
          if (sts.pop_hit) begin
            state_next = ST_FETCH;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch_load = 1'b1;
        out_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_tvalid = out_valid;

endmodule

>>> rtl/erq_dpath.sv
// datapath of the event ring queue: event ram, indices, counters, result register
// depends on erq_pkg
module erq_dpath
  import erq_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                s_tuser,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tuser,
  input  ctrl_cmd_t           cmd,
  output dp_sts_t             sts
);

  localparam int AW = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;

  logic [EVT_W-1:0] mem [RING_DEPTH];
  logic [EVT_W-1:0] rd_data;
  logic [EVT_W-1:0] out_evt;

  logic [AW-1:0]    wr_ptr, rd_ptr, wr_ptr_next, rd_ptr_next;
  logic [AW-1:0]    wr_adv, rd_adv;
  logic [CNT_W-1:0] drop_cnt, push_cnt;
  logic [OCC_W-1:0] occ;
  logic             ok;
  logic             full, empty, is_push, is_pop;
  logic             do_write;
  logic [AW:0]      diff;
  logic [31:0]      diff_wide;

  assign wr_adv = (wr_ptr == AW'(RING_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_adv = (rd_ptr == AW'(RING_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign full   = (wr_adv == rd_ptr);
  assign empty  = (wr_ptr == rd_ptr);

  assign is_push  = (s_tuser == REQ_PUSH);
  assign is_pop   = (s_tuser == REQ_POP);
  assign do_write = cmd.accept && is_push && !full;

  assign sts.pop_hit = is_pop && !empty;

  assign wr_ptr_next = do_write ? wr_adv : wr_ptr;
  assign rd_ptr_next = (cmd.accept && sts.pop_hit) ? rd_adv : rd_ptr;

  // occupancy after this request
  always_comb begin
    if (wr_ptr_next >= rd_ptr_next) begin
      diff = {1'b0, wr_ptr_next} - {1'b0, rd_ptr_next};
    end else begin
      diff = {1'b0, wr_ptr_next} + (AW + 1)'(RING_DEPTH) - {1'b0, rd_ptr_next};
    end
    diff_wide = 32'(diff);
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_ptr] <= s_tdata;
    end
    if (cmd.accept) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      drop_cnt <= '0;
      push_cnt <= '0;
    end else if (cmd.accept) begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      if (is_push) begin
        push_cnt <= push_cnt + 1'b1;
        if (full) begin
          drop_cnt <= drop_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ok      <= do_write || sts.pop_hit;
      occ     <= diff_wide[OCC_W-1:0];
      out_evt <= '0;
    end else if (cmd.fetch_load) begin
      out_evt <= rd_data;
    end
  end

  assign m_tuser = ok;
  assign m_tdata = {{M_PAD_W{1'b0}}, push_cnt, drop_cnt, occ, out_evt};

endmodule

>>> rtl/erq_chk.sv
// port-level checker for the event ring queue, bound to the top level
// depends on erq_pkg and event_ring_queue_drop_on_full_top_macros.svh
`include "event_ring_queue_drop_on_full_top_macros.svh"

module erq_chk
  import erq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [S_DATA_W-1:0] s_tdata,
  input logic                s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tuser
);

  `ERQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped under stall")
  `ERQ_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed under stall")
  `ERQ_ASSERT_IMPL(a_fail_zero, m_tvalid && !m_tuser, m_tdata[EVT_W-1:0] == '0, "failed request returned event data")
  `ERQ_ASSERT_NEXT(a_push_prompt, s_tvalid && s_tready && (s_tuser == REQ_PUSH), m_tvalid && (m_tdata[EVT_W-1:0] == '0), "push result late or carries event data")

endmodule

bind event_ring_queue_drop_on_full_top erq_chk u_chk (.*);

>>> sim/tb_event_ring_queue_drop_on_full_top.sv
// testbench for event_ring_queue_drop_on_full_top: pushes and pops touch events,
// predicts each result with its own copy of the ring and the counters,
// checks every field but the pad; depends on erq_pkg and the rtl of the event ring queue
module tb_event_ring_queue_drop_on_full_top;
  timeunit 1ns;
  timeprecision 1ps;
  import erq_pkg::*;

  localparam int QUEUE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 200000;

  // first field in the lowest bits
  typedef struct packed {
    logic signed [FIELD_W-1:0] pointer;
    logic signed [FIELD_W-1:0] pressure;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] action;
    logic signed [FIELD_W-1:0] kind;
  } touch_event_t;

  typedef struct packed {
    logic [M_PAD_W-1:0] pad;
    logic [CNT_W-1:0]   push_count;
    logic [CNT_W-1:0]   drop_count;
    logic [OCC_W-1:0]   occupancy;
    touch_event_t       evt;
  } queue_status_t;

  typedef struct {
    logic          ok;
    queue_status_t status;
  } queue_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;   // in_kind, in_action, in_x, in_y, in_pressure, in_pointer
  logic                s_tuser = REQ_PUSH;   // req_type
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;   // out_kind .. out_pointer, occupancy, drop_count, push_count
  logic                m_tuser;   // ok

  logic          steady_flow = 1'b0;
  int            error_count = 0;
  int            results_seen = 0;
  int            cycle_count = 0;
  queue_result_t pending_results[$];

  touch_event_t ring_mem[QUEUE_DEPTH];
  int           wr_idx = 0;
  int           rd_idx = 0;
  logic [31:0]  drop_total = '0;
  logic [31:0]  push_total = '0;

  event_ring_queue_drop_on_full_top #(
    .RING_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int held_count();
    return (wr_idx + QUEUE_DEPTH - rd_idx) % QUEUE_DEPTH;
  endfunction

  function automatic queue_result_t predict_queue_result(logic req, touch_event_t ev);
    queue_result_t r;
    int nxt;
    r.ok = 1'b0;
    r.status = '0;
    if (req == REQ_PUSH) begin
      nxt = (wr_idx + 1) % QUEUE_DEPTH;
      push_total = push_total + 1;
      if (nxt == rd_idx) begin
        drop_total = drop_total + 1;
      end else begin
        ring_mem[wr_idx] = ev;
        wr_idx = nxt;
        r.ok = 1'b1;
      end
    end else if (rd_idx != wr_idx) begin
      r.status.evt = ring_mem[rd_idx];
      rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
      r.ok = 1'b1;
    end
    r.status.occupancy = OCC_W'(held_count());
    r.status.drop_count = drop_total;
    r.status.push_count = push_total;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic touch_event_t random_event();
    touch_event_t ev;
    ev.kind = rand_word();
    ev.action = rand_word();
    ev.x = rand_word();
    ev.y = rand_word();
    ev.pressure = rand_word();
    ev.pointer = rand_word();
    return ev;
  endfunction

  task automatic report_error(string msg);
    $display("error: %s", msg);
    error_count++;
  endtask

  task automatic check_field(string name, int idx, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %h expected %h", idx, name, got, want));
  endtask

  // one request; returns at the edge where it was taken
  task automatic send_request(input logic req, input touch_event_t ev);
    while (!steady_flow && $urandom_range(0, 99) < 13) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= ev;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    pending_results.push_back(predict_queue_result(req, ev));
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_pops();
    repeat (2) send_request(REQ_POP, random_event());
  endtask

  task automatic test_field_extremes();
    send_request(REQ_PUSH, '{default: 32'h0000_0000});
    send_request(REQ_PUSH, '{default: 32'hffff_ffff});
    send_request(REQ_PUSH, '{default: 32'h8000_0000});
    send_request(REQ_POP, '{default: 32'h0000_0000});
    send_request(REQ_PUSH, '{default: 32'h7fff_ffff});
    send_request(REQ_PUSH, '{kind: 32'haaaa_aaaa, action: 32'h5555_5555, x: 32'haaaa_aaaa,
                             y: 32'h5555_5555, pressure: 32'haaaa_aaaa, pointer: 32'h5555_5555});
    send_request(REQ_PUSH, '{kind: 1, action: 2, x: 30000, y: -15000, pressure: 10000,
                             pointer: 7});
    repeat (6) send_request(REQ_POP, '{default: 32'hffff_ffff});
  endtask

  task automatic test_full_queue();
    while (held_count() < QUEUE_DEPTH - 1) send_request(REQ_PUSH, random_event());
    repeat (3) send_request(REQ_PUSH, random_event());
    send_request(REQ_POP, random_event());
    send_request(REQ_PUSH, random_event());
    send_request(REQ_PUSH, random_event());
    while (held_count() > 0) send_request(REQ_POP, random_event());
    send_request(REQ_POP, random_event());
  endtask

  task automatic test_random_traffic();
    int push_pct;
    push_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 4))
          0: push_pct = 95;
          1: push_pct = 75;
          2: push_pct = 50;
          3: push_pct = 25;
          default: push_pct = 5;
        endcase
      end
      if (n == 800) wait_for_results();
      steady_flow <= (n >= 450 && n < 650);
      send_request(($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP, random_event());
    end
    steady_flow <= 1'b0;
  endtask

  always @(posedge clk) begin
    m_tready <= steady_flow || ($urandom_range(0, 99) >= 13);
  end

  always @(negedge clk) begin : result_check
    queue_result_t want;
    queue_status_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with no request pending", results_seen));
      end else begin
        want = pending_results.pop_front();
        check_field("ok", results_seen, 32'(m_tuser), 32'(want.ok));
        check_field("kind", results_seen, got.evt.kind, want.status.evt.kind);
        check_field("action", results_seen, got.evt.action, want.status.evt.action);
        check_field("x", results_seen, got.evt.x, want.status.evt.x);
        check_field("y", results_seen, got.evt.y, want.status.evt.y);
        check_field("pressure", results_seen, got.evt.pressure, want.status.evt.pressure);
        check_field("pointer", results_seen, got.evt.pointer, want.status.evt.pointer);
        check_field("occupancy", results_seen, 32'(got.occupancy),
                    32'(want.status.occupancy));
        check_field("drop_count", results_seen, got.drop_count, want.status.drop_count);
        check_field("push_count", results_seen, got.push_count, want.status.push_count);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pops();
    test_field_extremes();
    test_full_queue();
    test_random_traffic();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> event_ring_queue_drop_on_full_top.f
+incdir+rtl
rtl/erq_pkg.sv
rtl/erq_ctrl.sv
rtl/erq_dpath.sv
rtl/event_ring_queue_drop_on_full_top.sv
rtl/erq_chk.sv
sim/tb_event_ring_queue_drop_on_full_top.sv
